FILE: src/tbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbc_pkg;

    localparam int TAG_W  = 32;
    localparam int SLOT_W = 3;

    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_tag EMPTY_TAG = '0;

    // lookup outcome handed from the directory to the result register
    typedef struct packed {
        logic  hit;
        t_slot slot;
    } t_result;

endpackage

`default_nettype wire

FILE: src/transpose_block_cache_lookup.sv
// An accepted word is held in the input register, then its result word moves to the output register.
// Throughput: one word per cycle while i_ready holds; the directory compare, the first-match search
// and the neighbor swap all settle between the input and result registers.
// Reset (synchronous, active low): all tags empty, entry i holds slot i mod 8,
// both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module transpose_block_cache_lookup #(
    parameter int ENTRIES = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire tbc_pkg::t_tag         i_tag,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_hit,
    output tbc_pkg::t_slot             o_buffer_slot
);

    import tbc_pkg::*;

    // input register: holds the word waiting for its directory pass
    logic    r_in_valid;
    t_tag    r_tag;

    // result register
    logic    r_out_valid;
    t_result r_result;

    t_result dir_result;
    logic    advance;

    // advance the input stage whenever the result register is free or drains
    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    // the directory updates only when its lookup moves into the result register,
    // so each word sees the state left by the one before it
    tbc_dir #(.ENTRIES(ENTRIES)) u_dir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (r_in_valid && advance),
        .i_tag    (r_tag),
        .o_result (dir_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tag <= i_tag;
        end
    end

    // result register: load a fresh result or drop the one just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= dir_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_result.hit;
    assign o_buffer_slot = r_result.slot;

endmodule

`default_nettype wire

FILE: src/tbc_first_set.sv
`timescale 1ns / 1ps
`default_nettype none

module tbc_first_set #(
    parameter int WIDTH = 5
) (
    input  wire logic [WIDTH-1:0]         i_req,
    output logic                          o_found,
    output logic [$clog2(WIDTH)-1:0]      o_index
);

    localparam int IDX_W = $clog2(WIDTH);

    // scan from the top down so the lowest set bit wins
    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_req[i]) begin
                o_found = 1'b1;
                o_index = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/tbc_dir.sv
`timescale 1ns / 1ps
`default_nettype none

module tbc_dir #(
    parameter int ENTRIES = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_lookup,
    input  wire tbc_pkg::t_tag i_tag,
    output tbc_pkg::t_result   o_result
);

    import tbc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    t_tag  r_tags  [ENTRIES];
    t_slot r_slots [ENTRIES];
    t_tag  n_tags  [ENTRIES];
    t_slot n_slots [ENTRIES];

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] empty;
    logic               hit;
    logic               has_empty;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   empty_idx;
    logic [IDX_W-1:0]   prev_idx;
    logic [IDX_W-1:0]   victim;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (r_tags[i] == i_tag);
            empty[i] = (r_tags[i] == EMPTY_TAG);
        end
    end

    tbc_first_set #(.WIDTH(ENTRIES)) u_hit_find (
        .i_req   (match),
        .o_found (hit),
        .o_index (hit_idx)
    );

    tbc_first_set #(.WIDTH(ENTRIES)) u_empty_find (
        .i_req   (empty),
        .o_found (has_empty),
        .o_index (empty_idx)
    );

    assign prev_idx = hit_idx - IDX_W'(1);
    assign victim   = has_empty ? empty_idx : IDX_W'(ENTRIES - 1);

    always_comb begin
        o_result.hit  = hit;
        o_result.slot = hit ? r_slots[hit_idx] : r_slots[victim];
    end

    // hit: swap with the neighbor in front unless already at entry 0; miss: victim takes the tag
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_tags[i]  = r_tags[i];
            n_slots[i] = r_slots[i];
        end
        if (hit) begin
            if (hit_idx != '0) begin
                n_tags[prev_idx]  = r_tags[hit_idx];
                n_slots[prev_idx] = r_slots[hit_idx];
                n_tags[hit_idx]   = r_tags[prev_idx];
                n_slots[hit_idx]  = r_slots[prev_idx];
            end
        end else begin
            n_tags[victim] = i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_tags[i]  <= EMPTY_TAG;
                r_slots[i] <= SLOT_W'(i);
            end
        end else if (i_lookup) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_tags[i]  <= n_tags[i];
                r_slots[i] <= n_slots[i];
            end
        end
    end

endmodule

`default_nettype wire
